@@ rtl/isq_pkg.sv @@
package isq_pkg;

  // Default sizing of the store.
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed field widths on the ports.
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned ENTRY_W  = 32;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND    = 3'd0,
    KIND_INSERT    = 3'd1,
    KIND_OVERWRITE = 3'd2,
    KIND_REMOVE    = 3'd3,
    KIND_REMVAL    = 3'd4,
    KIND_DUMP      = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_INDEX    = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_FINISH,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESULT
  } state_t;

  // One result beat handed from the sequencer to the output register.
  typedef struct packed {
    logic                valid;
    status_t             status;
    logic [LEN_W-1:0]    length;
    logic [ENTRY_W-1:0]  entry;
    logic                last;
  } res_t;

endpackage

@@ rtl/indexed_sequence_store.sv @@
// Channel | Beat fields (lowest bits first)                  | Marker
// in_     | tdata: value[31:0], position[36:32]; tuser: kind | -
// out_    | tdata: status[2:0], length[7:3], entry[39:8]     | tlast = last
//
// One operation at a time: in_tready is high only in the idle state. Insert
// and remove shift the moved entries one by one before a finish step, remove
// by value reads and compares each entry scanned, and dump reads and sends
// each entry. Each beat leaves through an output register, which a low
// out_tready backs up into the sequencer. Reset is synchronous, active low,
// empties the list and idles the sequencer and output register, not the RAM.
module indexed_sequence_store #(
  parameter int unsigned CAPACITY   = isq_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = isq_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // value[31:0], position[36:32], zero padding[39:37]
  input  logic [isq_pkg::IN_TDATA_W-1:0]      in_tdata,
  // kind[2:0]
  input  logic [isq_pkg::KIND_W-1:0]          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status[2:0], length[7:3], entry[39:8]
  output logic [isq_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);

  localparam int unsigned AW = $clog2(CAPACITY);

  isq_pkg::res_t res;
  logic          res_ready;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic                             out_valid_r;
  logic [isq_pkg::OUT_TDATA_W-1:0]  out_data_r;
  logic                             out_last_r;

  isq_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (isq_pkg::kind_t'(in_tuser)),
    .in_value  (signed'(in_tdata[isq_pkg::VALUE_W-1:0])),
    .in_pos    (in_tdata[isq_pkg::VALUE_W +: isq_pkg::POS_W]),
    .res       (res),
    .res_ready (res_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  isq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The output register takes a new beat whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_data_r <= {res.entry, res.length, res.status};
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ rtl/isq_ram.sv @@
module isq_ram #(
  parameter int unsigned DEPTH = isq_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH = isq_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is registered and holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/isq_ctrl.sv @@
module isq_ctrl #(
  parameter int unsigned CAPACITY   = isq_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = isq_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  isq_pkg::kind_t                  in_kind,
  input  logic signed [isq_pkg::VALUE_W-1:0] in_value,
  input  logic [isq_pkg::POS_W-1:0]       in_pos,
  output isq_pkg::res_t                   res,
  input  logic                            res_ready,
  output logic                            mem_we,
  output logic [$clog2(CAPACITY)-1:0]     mem_waddr,
  output logic [DATA_WIDTH-1:0]           mem_wdata,
  output logic                            mem_re,
  output logic [$clog2(CAPACITY)-1:0]     mem_raddr,
  input  logic [DATA_WIDTH-1:0]           mem_rdata
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > isq_pkg::POS_W) ? CW : isq_pkg::POS_W;

  isq_pkg::state_t  state_r, state_nxt;
  isq_pkg::kind_t   kind_r, kind_nxt;
  isq_pkg::status_t status_r, status_nxt;
  logic [DATA_WIDTH-1:0]     val_r, val_nxt;
  logic [isq_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [AW-1:0]             i_r, i_nxt;
  logic [AW-1:0]             tgt_r, tgt_nxt;
  logic [AW-1:0]             wa_r, wa_nxt;
  logic                      ins_r, ins_nxt;
  logic                      pend_r, pend_nxt;

  logic empty, full, pos_gt_n, pos_ge_n, last_idx, more, match;
  logic [AW-1:0] src_idx;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(CAPACITY));
  assign pos_gt_n = (PW'(pos_r) > PW'(count_r));
  assign pos_ge_n = (PW'(pos_r) >= PW'(count_r));
  assign last_idx = ((CW'(i_r) + CW'(1)) == count_r);
  // Insert moves entries up toward the target; remove pulls them down, working up to the tail.
  assign more     = ins_r ? (i_r != tgt_r) : !last_idx;
  assign src_idx  = ins_r ? (i_r - AW'(1)) : (i_r + AW'(1));
  assign match    = (mem_rdata == val_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      isq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = isq_pkg::S_DECODE;
      end
      isq_pkg::S_DECODE: begin
        case (kind_r)
          isq_pkg::KIND_APPEND:
            state_nxt = full ? isq_pkg::S_RESULT : isq_pkg::S_SHIFT;
          isq_pkg::KIND_INSERT:
            state_nxt = (pos_gt_n || full) ? isq_pkg::S_RESULT : isq_pkg::S_SHIFT;
          isq_pkg::KIND_REMOVE:
            state_nxt = (empty || pos_ge_n) ? isq_pkg::S_RESULT : isq_pkg::S_SHIFT;
          isq_pkg::KIND_REMVAL:
            state_nxt = empty ? isq_pkg::S_RESULT : isq_pkg::S_SRCH_RD;
          isq_pkg::KIND_DUMP:
            state_nxt = empty ? isq_pkg::S_RESULT : isq_pkg::S_DUMP_RD;
          default:
            state_nxt = isq_pkg::S_RESULT;
        endcase
      end
      isq_pkg::S_SHIFT: begin
        if (!more) state_nxt = isq_pkg::S_FINISH;
      end
      isq_pkg::S_FINISH:   state_nxt = isq_pkg::S_RESULT;
      isq_pkg::S_SRCH_RD:  state_nxt = isq_pkg::S_SRCH_CMP;
      isq_pkg::S_SRCH_CMP: begin
        if (match) begin
          state_nxt = isq_pkg::S_SHIFT;
        end else if (last_idx) begin
          state_nxt = isq_pkg::S_RESULT;
        end else begin
          state_nxt = isq_pkg::S_SRCH_RD;
        end
      end
      isq_pkg::S_DUMP_RD:  state_nxt = isq_pkg::S_DUMP_OUT;
      isq_pkg::S_DUMP_OUT: begin
        if (res_ready) state_nxt = last_idx ? isq_pkg::S_IDLE : isq_pkg::S_DUMP_RD;
      end
      isq_pkg::S_RESULT: begin
        if (res_ready) state_nxt = isq_pkg::S_IDLE;
      end
      default: state_nxt = isq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt   = kind_r;
    status_nxt = status_r;
    val_nxt    = val_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    i_nxt      = i_r;
    tgt_nxt    = tgt_r;
    wa_nxt     = wa_r;
    ins_nxt    = ins_r;
    pend_nxt   = pend_r;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = val_r;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    res        = '0;
    res.length = isq_pkg::LEN_W'(count_r);
    case (state_r)
      isq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_nxt = in_kind;
          val_nxt  = DATA_WIDTH'(in_value);
          pos_nxt  = in_pos;
        end
      end
      isq_pkg::S_DECODE: begin
        status_nxt = isq_pkg::ST_OK;
        pend_nxt   = 1'b0;
        case (kind_r)
          isq_pkg::KIND_APPEND: begin
            if (full) begin
              status_nxt = isq_pkg::ST_FULL;
            end else begin
              ins_nxt = 1'b1;
              i_nxt   = AW'(count_r);
              tgt_nxt = AW'(count_r);
            end
          end
          isq_pkg::KIND_INSERT: begin
            if (pos_gt_n) begin
              status_nxt = isq_pkg::ST_INDEX;
            end else if (full) begin
              status_nxt = isq_pkg::ST_FULL;
            end else begin
              ins_nxt = 1'b1;
              i_nxt   = AW'(count_r);
              tgt_nxt = AW'(pos_r);
            end
          end
          isq_pkg::KIND_OVERWRITE: begin
            if (empty) begin
              status_nxt = isq_pkg::ST_EMPTY;
            end else if (pos_ge_n) begin
              status_nxt = isq_pkg::ST_INDEX;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AW'(pos_r);
            end
          end
          isq_pkg::KIND_REMOVE: begin
            if (empty) begin
              status_nxt = isq_pkg::ST_EMPTY;
            end else if (pos_ge_n) begin
              status_nxt = isq_pkg::ST_INDEX;
            end else begin
              ins_nxt = 1'b0;
              i_nxt   = AW'(pos_r);
            end
          end
          isq_pkg::KIND_REMVAL, isq_pkg::KIND_DUMP: begin
            if (empty) begin
              status_nxt = isq_pkg::ST_EMPTY;
            end else begin
              i_nxt = '0;
            end
          end
          default: ;
        endcase
      end
      isq_pkg::S_SHIFT: begin
        // Read of one entry overlaps with the write of the one read before it.
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wa_r;
          mem_wdata = mem_rdata;
        end
        if (more) begin
          mem_re    = 1'b1;
          mem_raddr = src_idx;
          wa_nxt    = i_r;
          i_nxt     = src_idx;
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
        end
      end
      isq_pkg::S_FINISH: begin
        if (ins_r) begin
          mem_we    = 1'b1;
          mem_waddr = tgt_r;
          count_nxt = count_r + CW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      isq_pkg::S_SRCH_RD, isq_pkg::S_DUMP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = i_r;
      end
      isq_pkg::S_SRCH_CMP: begin
        if (match) begin
          ins_nxt  = 1'b0;
          pend_nxt = 1'b0;
        end else if (last_idx) begin
          status_nxt = isq_pkg::ST_NOTFOUND;
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      isq_pkg::S_DUMP_OUT: begin
        res.valid  = 1'b1;
        res.status = isq_pkg::ST_OK;
        res.entry  = isq_pkg::ENTRY_W'(mem_rdata);
        res.last   = last_idx;
        if (res_ready) i_nxt = i_r + AW'(1);
      end
      isq_pkg::S_RESULT: begin
        res.valid  = 1'b1;
        res.status = status_r;
        res.last   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isq_pkg::S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    status_r <= status_nxt;
    val_r    <= val_nxt;
    pos_r    <= pos_nxt;
    i_r      <= i_nxt;
    tgt_r    <= tgt_nxt;
    wa_r     <= wa_nxt;
    ins_r    <= ins_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("list length exceeds capacity");

  a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("shift reads and writes the same entry in one cycle");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != isq_pkg::S_IDLE && state_nxt == isq_pkg::S_IDLE)
      |-> (res.valid && res_ready && res.last))
    else $error("sequencer went idle without handing off the final beat");

  a_count_moves_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(count_r)) |-> ($past(state_r) == isq_pkg::S_FINISH))
    else $error("length changed outside the finish step");
`endif

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = isq_pkg::CAPACITY_DEF;

  // The two operation codes that the block ignores. They still produce one
  // status beat that carries the current length.
  localparam logic [isq_pkg::KIND_W-1:0] KIND_SPARE6 = 3'd6;
  localparam logic [isq_pkg::KIND_W-1:0] KIND_SPARE7 = 3'd7;

  // Shaping modes for the random part; the middle one is the mixed mode.
  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 2;

  localparam int RANDOM_ITEMS = 356;
  localparam int CALM_TAIL    = 50;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = 64;

  // One list operation as it travels on the input channel.
  typedef struct packed {
    logic [isq_pkg::KIND_W-1:0]  kind;
    logic [isq_pkg::VALUE_W-1:0] value;
    logic [isq_pkg::POS_W-1:0]   position;
    logic                        drain_first;
  } list_op_t;

  // One result beat as it travels on the output channel.
  typedef struct packed {
    isq_pkg::status_t            status;
    logic [isq_pkg::LEN_W-1:0]   length;
    logic [isq_pkg::ENTRY_W-1:0] entry;
    logic                        last;
  } list_beat_t;

  // Contents of the bounded list: only the first n entries mean anything.
  typedef struct packed {
    logic [CAP-1:0][isq_pkg::VALUE_W-1:0] e;
    logic [isq_pkg::LEN_W-1:0]            n;
  } list_state_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [isq_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [isq_pkg::KIND_W-1:0]      in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [isq_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tlast;

  // Operations waiting to be offered, and the beats the list must still return.
  list_op_t    pending_ops[$];
  list_beat_t  expected_beats[$];

  // The list as the stimulus planner sees it, and the list as the checker sees it.
  list_state_t plan_list;
  list_state_t shadow_list;

  int unsigned mismatches = 0;
  bit          in_taken = 1'b0;
  bit          offering = 1'b0;
  bit          long_hold = 1'b0;
  list_op_t    cur_op = '0;
  int          in_gap = 0;
  int          out_gap = 0;

  always #2 clk = ~clk;

  indexed_sequence_store u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Puts a value at a position and moves the entries behind it one place up.
  // The position is checked before the fill level, so a bad position on a full
  // list reports an index error rather than a full list.
  function automatic isq_pkg::status_t list_insert(inout list_state_t s,
                                                   input int unsigned at,
                                                   input logic [isq_pkg::VALUE_W-1:0] v);
    int i;
    if (at > s.n) return isq_pkg::ST_INDEX;
    if (s.n >= CAP) return isq_pkg::ST_FULL;
    for (i = int'(s.n); i > int'(at); i--) s.e[i] = s.e[i-1];
    s.e[at] = v;
    s.n = s.n + 1'b1;
    return isq_pkg::ST_OK;
  endfunction

  // Closes the gap left by the entry at a position.
  function automatic void list_remove(inout list_state_t s, input int unsigned at);
    int i;
    for (i = int'(at); i + 1 < int'(s.n); i++) s.e[i] = s.e[i+1];
    s.n = s.n - 1'b1;
  endfunction

  // Applies one operation to a list and returns the beats it should produce.
  function automatic void apply_list_op(inout list_state_t s, input list_op_t op,
                                        output list_beat_t beats[$]);
    isq_pkg::status_t st;
    int unsigned      at;
    int               hit;
    int               i;
    list_beat_t       b;
    beats = {};
    st    = isq_pkg::ST_OK;
    at    = op.position;
    hit   = -1;
    case (op.kind)
      isq_pkg::KIND_APPEND: begin
        st = list_insert(s, s.n, op.value);
      end
      isq_pkg::KIND_INSERT: begin
        st = list_insert(s, at, op.value);
      end
      isq_pkg::KIND_OVERWRITE, isq_pkg::KIND_REMOVE: begin
        if (s.n == 0) st = isq_pkg::ST_EMPTY;
        else if (at >= s.n) st = isq_pkg::ST_INDEX;
        else if (op.kind == isq_pkg::KIND_OVERWRITE) s.e[at] = op.value;
        else list_remove(s, at);
      end
      isq_pkg::KIND_REMVAL: begin
        if (s.n == 0) begin
          st = isq_pkg::ST_EMPTY;
        end else begin
          // Only the first equal entry goes away.
          for (i = 0; i < int'(s.n) && hit < 0; i++) begin
            if (s.e[i] == op.value) hit = i;
          end
          if (hit < 0) st = isq_pkg::ST_NOTFOUND;
          else list_remove(s, hit);
        end
      end
      isq_pkg::KIND_DUMP: begin
        if (s.n == 0) begin
          st = isq_pkg::ST_EMPTY;
        end else begin
          for (i = 0; i < int'(s.n); i++) begin
            b.status = isq_pkg::ST_OK;
            b.length = s.n;
            b.entry  = s.e[i];
            b.last   = (i + 1 == int'(s.n));
            beats.push_back(b);
          end
          return;
        end
      end
      default: begin
      end
    endcase
    b.status = st;
    b.length = s.n;
    b.entry  = '0;
    b.last   = 1'b1;
    beats.push_back(b);
  endfunction

  task automatic report_mismatch(input string what, input list_beat_t want,
                                 input list_beat_t got);
    $display("%0t ns: %s: want st=%0d len=%0d entry=%0d last=%b, %s",
             $time, what, want.status, want.length, $signed(want.entry), want.last,
             $sformatf("got st=%0d len=%0d entry=%0d last=%b",
                       got.status, got.length, $signed(got.entry), got.last));
    mismatches++;
  endtask

  // Queues one operation for the driver and keeps the planner's list in step,
  // so that later choices of position and value know the real fill level.
  task automatic plan_op(input logic [isq_pkg::KIND_W-1:0] kind,
                         input logic [isq_pkg::VALUE_W-1:0] value,
                         input int unsigned position, input bit drain_first = 1'b0);
    list_op_t   op;
    list_beat_t unused[$];
    op.kind        = kind;
    op.value       = value;
    op.position    = position[isq_pkg::POS_W-1:0];
    op.drain_first = drain_first;
    pending_ops.push_back(op);
    apply_list_op(plan_list, op, unused);
  endtask

  // Values lean toward a small pool so that searches hit and duplicates occur,
  // with full-width random words and the extremes mixed in.
  function automatic logic [isq_pkg::VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom;
    if (r < 50) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom_range(0, 7) - 3;
  endfunction

  // Draws one operation whose mix depends on the phase of the random part.
  task automatic plan_random_op(input int mode, input bit drain_first);
    int unsigned                 r;
    int unsigned                 n;
    int unsigned                 pos;
    logic [isq_pkg::VALUE_W-1:0] v;
    logic [isq_pkg::KIND_W-1:0]  kind;
    n = plan_list.n;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        if (r < 40) kind = isq_pkg::KIND_APPEND;
        else if (r < 75) kind = isq_pkg::KIND_INSERT;
        else if (r < 82) kind = isq_pkg::KIND_OVERWRITE;
        else if (r < 88) kind = isq_pkg::KIND_REMVAL;
        else if (r < 94) kind = isq_pkg::KIND_REMOVE;
        else if (r < 98) kind = isq_pkg::KIND_DUMP;
        else kind = $urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7;
      end
      MODE_SHRINK: begin
        if (r < 10) kind = isq_pkg::KIND_APPEND;
        else if (r < 20) kind = isq_pkg::KIND_INSERT;
        else if (r < 30) kind = isq_pkg::KIND_OVERWRITE;
        else if (r < 60) kind = isq_pkg::KIND_REMOVE;
        else if (r < 88) kind = isq_pkg::KIND_REMVAL;
        else if (r < 96) kind = isq_pkg::KIND_DUMP;
        else kind = $urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7;
      end
      default: begin
        if (r < 20) kind = isq_pkg::KIND_APPEND;
        else if (r < 38) kind = isq_pkg::KIND_INSERT;
        else if (r < 52) kind = isq_pkg::KIND_OVERWRITE;
        else if (r < 66) kind = isq_pkg::KIND_REMOVE;
        else if (r < 80) kind = isq_pkg::KIND_REMVAL;
        else if (r < 92) kind = isq_pkg::KIND_DUMP;
        else kind = $urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7;
      end
    endcase

    // Mostly legal positions, with a share anywhere from 0 to CAP.
    pos = $urandom_range(0, CAP);
    if ($urandom_range(0, 99) < 85) begin
      if (kind == isq_pkg::KIND_INSERT) pos = $urandom_range(0, n);
      else if (n > 0 && (kind == isq_pkg::KIND_OVERWRITE || kind == isq_pkg::KIND_REMOVE))
        pos = $urandom_range(0, n - 1);
    end

    v = pick_value();
    if (kind == isq_pkg::KIND_REMVAL && n > 0 && $urandom_range(0, 2) == 0)
      v = plan_list.e[$urandom_range(0, n - 1)];
    plan_op(kind, v, pos, drain_first);
  endtask

  // Checker: every accepted input beat is run through the predictor, and
  // every accepted output beat is matched against the oldest expectation.
  always @(posedge clk) begin
    list_op_t   seen;
    list_beat_t fresh[$];
    list_beat_t got;
    list_beat_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen.kind        = in_tuser;
        seen.value       = in_tdata[isq_pkg::VALUE_W-1:0];
        seen.position    = in_tdata[isq_pkg::VALUE_W+isq_pkg::POS_W-1:isq_pkg::VALUE_W];
        seen.drain_first = 1'b0;
        apply_list_op(shadow_list, seen, fresh);
        foreach (fresh[k]) expected_beats.push_back(fresh[k]);
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        got.status = isq_pkg::status_t'(out_tdata[isq_pkg::STATUS_W-1:0]);
        got.length = out_tdata[isq_pkg::STATUS_W +: isq_pkg::LEN_W];
        got.entry  = out_tdata[isq_pkg::STATUS_W+isq_pkg::LEN_W +: isq_pkg::ENTRY_W];
        got.last   = out_tlast;
        if (expected_beats.size() == 0) begin
          report_mismatch("result beat with nothing expected", '0, got);
        end else begin
          want = expected_beats.pop_front();
          if (got.status !== want.status) report_mismatch("status", want, got);
          if (got.length !== want.length) report_mismatch("length", want, got);
          if (got.entry !== want.entry) report_mismatch("entry", want, got);
          if (got.last !== want.last) report_mismatch("last", want, got);
        end
      end
    end
  end

  // Sender: offers queued operations at the falling edge. After a beat goes
  // through it may sit out a random burst, except in the calm tail. An
  // operation marked to drain first is held back until every expected beat
  // has come out, which leaves the block fully idle in front of it.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        offering = 1'b0;
        in_taken = 1'b0;
      end
      if (!offering) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].drain_first && expected_beats.size() > 0)) begin
          cur_op   = pending_ops.pop_front();
          offering = 1'b1;
          if (pending_ops.size() >= CALM_TAIL && $urandom_range(0, 3) == 0)
            in_gap = $urandom_range(1, 8);
        end
      end
      in_tvalid <= offering;
      in_tdata  <= {{(isq_pkg::IN_TDATA_W-isq_pkg::VALUE_W-isq_pkg::POS_W){1'b0}},
                    cur_op.position, cur_op.value};
      in_tuser  <= cur_op.kind;
    end
  end

  // Receiver: ready by default, with random stall bursts until the calm tail,
  // and forced low while the long hold-off runs.
  always @(negedge clk) begin
    bit ready;
    ready = 1'b1;
    if (out_gap > 0) begin
      out_gap--;
      ready = 1'b0;
    end else if (pending_ops.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(1, 8) - 1;
      ready   = 1'b0;
    end
    out_tready <= ready && !long_hold;
  end

  // Long hold-off: once the directed beats are through, the receiver stays
  // away for a fixed stretch while the sender keeps offering, so the output
  // register and the sequencer fill and in_tready has to drop.
  initial begin
    wait (rst_n);
    wait (pending_ops.size() < RANDOM_ITEMS - 10);
    @(posedge clk);
    long_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    int mode;
    int phase;
    int steps;
    int planned;
    plan_list   = '0;
    shadow_list = '0;

    // Directed part: the empty list, both extremes of the value, inserts at
    // the front and at the end, bad positions, a search miss, removal of the
    // first of two equal entries, the two ignored codes and dumps.
    plan_op(isq_pkg::KIND_DUMP, 32'd0, 0);
    plan_op(isq_pkg::KIND_REMOVE, 32'd0, 0);
    plan_op(isq_pkg::KIND_OVERWRITE, 32'd7, 0);
    plan_op(isq_pkg::KIND_REMVAL, 32'd0, 0);
    plan_op(isq_pkg::KIND_INSERT, 32'd1, 1);
    plan_op(isq_pkg::KIND_INSERT, 32'h8000_0000, 0);
    plan_op(isq_pkg::KIND_APPEND, 32'h7FFF_FFFF, 0);
    plan_op(isq_pkg::KIND_INSERT, 32'hFFFF_FFFF, 0);
    plan_op(isq_pkg::KIND_INSERT, 32'd0, 3);
    plan_op(isq_pkg::KIND_INSERT, 32'd9, CAP);
    plan_op(isq_pkg::KIND_OVERWRITE, 32'd9, 4);
    plan_op(isq_pkg::KIND_OVERWRITE, 32'h5A5A_5A5A, 1);
    plan_op(isq_pkg::KIND_REMOVE, 32'd0, CAP);
    plan_op(isq_pkg::KIND_REMVAL, 32'd12345, 0);
    plan_op(isq_pkg::KIND_APPEND, 32'hFFFF_FFFF, 0);
    plan_op(isq_pkg::KIND_REMVAL, 32'hFFFF_FFFF, 0);
    plan_op(KIND_SPARE6, 32'hA5A5_A5A5, CAP);
    plan_op(KIND_SPARE7, 32'h1234_5678, 5);
    plan_op(isq_pkg::KIND_DUMP, 32'd0, 0);
    plan_op(isq_pkg::KIND_REMOVE, 32'd0, 3);
    plan_op(isq_pkg::KIND_REMOVE, 32'd0, 0);
    plan_op(isq_pkg::KIND_DUMP, 32'd0, 0);

    // Random part in phases. The first phase grows the list until it is full (or for
    // at most 60 steps) and then keeps pushing, so full-list refusals and a full dump occur early.
    planned = 0;
    phase   = 0;
    while (planned < RANDOM_ITEMS) begin
      if (phase == 0) begin
        steps = 0;
        while (plan_list.n < CAP && steps < 60) begin
          plan_random_op(MODE_GROW, 1'b0);
          steps++;
        end
        plan_op(isq_pkg::KIND_APPEND, pick_value(), 0);
        plan_op(isq_pkg::KIND_INSERT, pick_value(), CAP);
        plan_op(isq_pkg::KIND_INSERT, pick_value(), 0);
        plan_op(isq_pkg::KIND_DUMP, 32'd0, 0);
        planned += steps + 4;
      end else begin
        mode  = $urandom_range(MODE_GROW, MODE_SHRINK);
        steps = $urandom_range(10, 30);
        for (int k = 0; k < steps; k++) begin
          // Every fourth phase opens with an operation that waits for the
          // block to drain completely.
          plan_random_op(mode, (k == 0) && (phase % 4 == 1));
        end
        planned += steps;
      end
      phase++;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() > 0 || offering || expected_beats.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/isq_pkg.sv
rtl/isq_ram.sv
rtl/isq_ctrl.sv
rtl/indexed_sequence_store.sv
tb/tb_top.sv
